### design/mfle_pkg.sv
// mfle_pkg: shared widths, codes and command/status types of the mel filterbank log energy unit
// no dependencies; imported by every module of the block except mfle_ram
`default_nettype none

package mfle_pkg;

	localparam int FILT_CNT_DEF = 26;
	localparam int NUM_BINS_DEF = 257;

	localparam int FSEL_W   = 5;
	localparam int BIN_W    = 9;
	localparam int WEIGHT_W = 16;
	localparam int POWER_W  = 32;
	localparam int PROD_W   = WEIGHT_W + POWER_W;
	localparam int ACC_W    = 56;
	localparam int LOG_W    = 16;
	localparam int FRAC_W   = 10;
	localparam int EXP_W    = LOG_W - FRAC_W;
	localparam int FUSED_W  = 5;

	// binary point of the accumulator sits 31 bits up
	localparam int LOG_OFFSET = 31;

	localparam logic [FUSED_W-1:0] FUSED_RESET = 5'd26;

	localparam logic REQ_WEIGHT = 1'b0;

	typedef struct packed {
		logic load;       // capture the accepted request
		logic wr_weight;  // write the captured weight
		logic issue;      // start one multiply-accumulate for filter idx
		logic acc_rd;     // read accumulator idx for the log stage
		logic log_start;  // hand the read accumulator to the log unit
		logic last_filt;  // idx is the last active filter
		logic clear_acc;  // end of frame, drop all accumulators
	} mfle_cmd_t;

	typedef struct packed {
		logic req;
		logic last;
		logic bin_ok;
		logic wr_ok;
		logic pipe_busy;
		logic log_done;
	} mfle_status_t;

endpackage

`default_nettype wire

### design/mfle_ram.sv
// mfle_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module mfle_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/mfle_log2.sv
// mfle_log2: iterative leading-one search and q6.10 log2 of one accumulator
// depends on mfle_pkg
`default_nettype none

module mfle_log2 import mfle_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [ACC_W-1:0]        value,
	output logic                         done,
	output logic signed [LOG_W-1:0]      result
);

	localparam int SH_W   = $clog2(ACC_W);
	localparam int BYTE_W = 8;
	localparam logic [EXP_W-1:0] EXP_TOP = EXP_W'(ACC_W - 1 - LOG_OFFSET);

	logic                    run_q;
	logic                    done_q;
	logic [ACC_W-1:0]        norm_q;
	logic [SH_W-1:0]         sh_q;
	logic signed [LOG_W-1:0] result_q;
	logic                    top_set;
	logic                    top_byte_zero;

	assign top_set       = norm_q[ACC_W-1];
	assign top_byte_zero = (norm_q[ACC_W-1 -: BYTE_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && top_set) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// coarse byte steps first, then single bits, until the leading one is on top
	always_ff @(posedge clk) begin
		if (start) begin
			norm_q <= (value == '0) ? ACC_W'(1) : value;
			sh_q   <= '0;
		end else if (run_q) begin
			if (top_set) begin
				result_q <= {EXP_TOP - EXP_W'(sh_q), norm_q[ACC_W-2 -: FRAC_W]};
			end else if (top_byte_zero) begin
				norm_q <= norm_q << BYTE_W;
				sh_q   <= sh_q + SH_W'(BYTE_W);
			end else begin
				norm_q <= norm_q << 1;
				sh_q   <= sh_q + SH_W'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### design/mfle_datapath.sv
// mfle_datapath: request capture, weight and accumulator rams, mac pipeline, log unit
// depends on mfle_pkg, mfle_ram, mfle_log2
`default_nettype none

module mfle_datapath import mfle_pkg::*; #(
	parameter int FILT_CNT = FILT_CNT_DEF,
	parameter int NUM_BINS = NUM_BINS_DEF,
	localparam int FIDX_W  = (FILT_CNT > 1) ? $clog2(FILT_CNT) : 1,
	localparam int WDEPTH  = FILT_CNT * NUM_BINS,
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mfle_cmd_t               cmd,
	input  wire logic [FIDX_W-1:0]       idx,
	input  wire logic                    req_type,
	input  wire logic [FSEL_W-1:0]       filter_sel,
	input  wire logic [BIN_W-1:0]        bin_index,
	input  wire logic [WEIGHT_W-1:0]     weight_value,
	input  wire logic [POWER_W-1:0]      bin_power,
	input  wire logic                    last_bin,
	output mfle_status_t                 status,
	output logic                         result_valid,
	output logic [FSEL_W-1:0]            filter_id,
	output logic signed [LOG_W-1:0]      log_energy,
	output logic                         frame_done
);

	localparam int SUM_W = ACC_W + 1;

	// captured request
	logic                req_q;
	logic [FSEL_W-1:0]   fsel_q;
	logic [BIN_W-1:0]    bin_q;
	logic [WEIGHT_W-1:0] wval_q;
	logic [POWER_W-1:0]  power_q;
	logic                last_q;

	logic [WADDR_W-1:0]  wptr_q;
	logic [31:0]         wr_lin;
	logic [WADDR_W-1:0]  wr_addr;
	logic [WEIGHT_W-1:0] w_rdata;
	logic [ACC_W-1:0]    acc_rdata;

	logic                valid_s1, valid_s2;
	logic [FIDX_W-1:0]   idx_s1, idx_s2;
	logic                accvld_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [ACC_W-1:0]    acc_s2;
	logic [SUM_W-1:0]    sum;
	logic [ACC_W-1:0]    acc_sat;
	logic [FILT_CNT-1:0] acc_vld_q;

	logic [FIDX_W-1:0]   id_q;
	logic                flast_q;
	logic [ACC_W-1:0]    log_in;
	logic                log_done;
	logic signed [LOG_W-1:0] log_res;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			fsel_q  <= filter_sel;
			bin_q   <= bin_index;
			wval_q  <= weight_value;
			power_q <= bin_power;
			last_q  <= last_bin;
			wptr_q  <= WADDR_W'(bin_index);
		end else if (cmd.issue) begin
			// next filter row of the same bin
			wptr_q <= wptr_q + WADDR_W'(NUM_BINS);
		end
	end

	assign wr_lin  = 32'(fsel_q) * 32'(NUM_BINS) + 32'(bin_q);
	assign wr_addr = wr_lin[WADDR_W-1:0];

	mfle_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (WDEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (cmd.wr_weight),
		.waddr (wr_addr),
		.wdata (wval_q),
		.re    (cmd.issue),
		.raddr (wptr_q),
		.rdata (w_rdata)
	);

	mfle_ram #(
		.WIDTH (ACC_W),
		.DEPTH (FILT_CNT)
	) u_acc_ram (
		.clk   (clk),
		.we    (valid_s2),
		.waddr (idx_s2),
		.wdata (acc_sat),
		.re    (cmd.issue | cmd.acc_rd),
		.raddr (idx),
		.rdata (acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			acc_vld_q <= '0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (cmd.clear_acc) begin
				acc_vld_q <= '0;
			end else if (valid_s2) begin
				acc_vld_q[idx_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue | cmd.acc_rd) begin
			idx_s1    <= idx;
			accvld_s1 <= acc_vld_q[idx];
		end
		idx_s2  <= idx_s1;
		prod_s2 <= PROD_W'(power_q) * PROD_W'(w_rdata);
		acc_s2  <= accvld_s1 ? acc_rdata : '0;
	end

	// accumulate with saturation at the top
	assign sum     = {1'b0, acc_s2} + SUM_W'(prod_s2);
	assign acc_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

	assign log_in = accvld_s1 ? acc_rdata : '0;

	always_ff @(posedge clk) begin
		if (cmd.log_start) begin
			id_q    <= idx;
			flast_q <= cmd.last_filt;
		end
	end

	mfle_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.value  (log_in),
		.done   (log_done),
		.result (log_res)
	);

	assign status.req       = req_q;
	assign status.last      = last_q;
	assign status.bin_ok    = int'(bin_q) < NUM_BINS;
	assign status.wr_ok     = (int'(fsel_q) < FILT_CNT) && (int'(bin_q) < NUM_BINS);
	assign status.pipe_busy = valid_s1 | valid_s2;
	assign status.log_done  = log_done;

	assign result_valid = log_done;
	assign filter_id    = FSEL_W'(id_q);
	assign log_energy   = log_res;
	assign frame_done   = flast_q;

endmodule

`default_nettype wire

### design/mfle_ctrl.sv
// mfle_ctrl: request sequencer, filter counter and filters_used register
// depends on mfle_pkg
`default_nettype none

module mfle_ctrl import mfle_pkg::*; #(
	parameter int FILT_CNT = FILT_CNT_DEF,
	localparam int FIDX_W = (FILT_CNT > 1) ? $clog2(FILT_CNT) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [FUSED_W-1:0] cfg_data,
	input  wire mfle_status_t       status,
	output mfle_cmd_t               cmd,
	output logic [FIDX_W-1:0]       idx
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MAC    = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_ORD    = 3'd4;
	localparam logic [2:0] S_OLOAD  = 3'd5;
	localparam logic [2:0] S_OWAIT  = 3'd6;

	logic [2:0]         state_q, state_d;
	logic [FIDX_W-1:0]  cnt_q, cnt_d;
	logic [FUSED_W-1:0] fused_q;
	logic [FIDX_W-1:0]  last_idx;
	logic               cnt_end;

	assign cfg_ready = 1'b1;

	// zero acts as one filter, anything past the bank as the whole bank
	always_comb begin
		if (fused_q == '0) begin
			last_idx = '0;
		end else if (int'(fused_q) > FILT_CNT) begin
			last_idx = FIDX_W'(FILT_CNT - 1);
		end else begin
			last_idx = FIDX_W'(fused_q - 1'b1);
		end
	end

	assign cnt_end = (cnt_q == last_idx);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.last_filt = cnt_end;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cnt_d = '0;
				if (status.req == REQ_WEIGHT) begin
					cmd.wr_weight = status.wr_ok;
					state_d       = S_IDLE;
				end else if (status.bin_ok) begin
					state_d = S_MAC;
				end else if (status.last) begin
					state_d = S_ORD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				if (cnt_end) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAIN: begin
				if (!status.pipe_busy) begin
					cnt_d   = '0;
					state_d = status.last ? S_ORD : S_IDLE;
				end
			end
			S_ORD: begin
				cmd.acc_rd = 1'b1;
				state_d    = S_OLOAD;
			end
			S_OLOAD: begin
				cmd.log_start = 1'b1;
				state_d       = S_OWAIT;
			end
			S_OWAIT: begin
				// result transfer happens in this cycle
				if (status.log_done) begin
					if (cnt_end) begin
						cmd.clear_acc = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cnt_d   = cnt_q + 1'b1;
						state_d = S_ORD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			fused_q <= FUSED_RESET;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				fused_q <= cfg_data;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign idx  = cnt_q;

endmodule

`default_nettype wire

### design/mel_filterbank_log_energy_unit.sv
// mel_filterbank_log_energy_unit: top level, controller plus datapath
// depends on mfle_pkg, mfle_ctrl, mfle_datapath
//
// usage
//   requests enter on start while busy is low; req_type 0 writes one filter
//   weight, req_type 1 delivers one power bin. weights must be written before
//   the bins that read them. filters_used is written over cfg_valid/cfg_ready
//   (ready is always high) by the user, only while the block is idle; not enforced.
//   a weight write keeps busy high for 1 cycle. a power bin keeps busy high
//   while one shared multiplier walks the active filters; weight and
//   accumulator ram reads feed a two stage mac pipeline.
//   a bin marked last_bin then reads each accumulator and runs the log2 unit,
//   which normalizes a byte or a bit per cycle until the leading one is on top.
//   each result appears for one cycle with result_valid, in filter order,
//   frame_done on the last; the receiver cannot stall, so nothing is held.
//   after the last result all accumulators are cleared and busy drops.
//   reset clears the accumulators and sets filters_used to 26; weight ram
//   content is undefined until written.
`default_nettype none

module mel_filterbank_log_energy_unit import mfle_pkg::*; #(
	parameter int FILT_CNT = FILT_CNT_DEF,
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 req_type,
	input  wire logic [FSEL_W-1:0]    filter_sel,
	input  wire logic [BIN_W-1:0]     bin_index,
	input  wire logic [WEIGHT_W-1:0]  weight_value,
	input  wire logic [POWER_W-1:0]   bin_power,
	input  wire logic                 last_bin,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [FUSED_W-1:0]   cfg_data,
	output logic                      result_valid,
	output logic [FSEL_W-1:0]         filter_id,
	output logic signed [LOG_W-1:0]   log_energy,
	output logic                      frame_done
);

	localparam int FIDX_W = (FILT_CNT > 1) ? $clog2(FILT_CNT) : 1;

	mfle_cmd_t         cmd;
	mfle_status_t      status;
	logic [FIDX_W-1:0] idx;

	mfle_ctrl #(
		.FILT_CNT (FILT_CNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd),
		.idx       (idx)
	);

	mfle_datapath #(
		.FILT_CNT (FILT_CNT),
		.NUM_BINS (NUM_BINS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.req_type     (req_type),
		.filter_sel   (filter_sel),
		.bin_index    (bin_index),
		.weight_value (weight_value),
		.bin_power    (bin_power),
		.last_bin     (last_bin),
		.status       (status),
		.result_valid (result_valid),
		.filter_id    (filter_id),
		.log_energy   (log_energy),
		.frame_done   (frame_done)
	);

`ifndef SYNTH
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside a request");

	a_frame_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |=> !busy)
		else $error("block still busy after the last result of a frame");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");
`endif

endmodule

`default_nettype wire

### verif/mfle_checker.sv
// mfle_checker: watches the request, config and result channels of the mel filterbank
// log energy unit, predicts every log2 result and compares them field by field
// depends on mfle_pkg
`timescale 1ns / 100ps

module mfle_checker import mfle_pkg::*; #(
	parameter int FILT_CNT = FILT_CNT_DEF,
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       req_type,
	input  logic [FSEL_W-1:0]          filter_sel,
	input  logic [BIN_W-1:0]           bin_index,
	input  logic [WEIGHT_W-1:0]        weight_value,
	input  logic [POWER_W-1:0]         bin_power,
	input  logic                       last_bin,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [FUSED_W-1:0]         cfg_data,
	input  logic                       result_valid,
	input  logic [FSEL_W-1:0]          filter_id,
	input  logic signed [LOG_W-1:0]    log_energy,
	input  logic                       frame_done,
	output int                         pending,
	output int                         fail_count
);

	typedef struct packed {
		logic [FSEL_W-1:0]       id;
		logic signed [LOG_W-1:0] loge;
		logic                    done;
	} band_energy_t;

	logic [WEIGHT_W-1:0] weight_mem [FILT_CNT][NUM_BINS];
	logic [ACC_W-1:0]    band_acc [FILT_CNT];
	logic [FUSED_W-1:0]  filters_used;
	band_energy_t        band_energy_q [$];

	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch, %s", $realtime, what);
		fail_count++;
	endtask

	// leading-one position minus the binary point, next 10 bits as a linear fraction
	function automatic logic signed [LOG_W-1:0] log2_energy(input logic [ACC_W-1:0] e);
		logic [ACC_W-1:0] v;
		logic [FRAC_W-1:0] mant;
		int msb;
		v = (e == '0) ? ACC_W'(1) : e;
		msb = 0;
		for (int i = 0; i < ACC_W; i++)
			if (v[i]) msb = i;
		if (msb >= FRAC_W)
			mant = FRAC_W'(v >> (msb - FRAC_W));
		else
			mant = FRAC_W'(v << (FRAC_W - msb));
		return LOG_W'((msb - LOG_OFFSET) * (1 << FRAC_W) + int'(mant));
	endfunction

	task automatic take_request();
		logic [PROD_W-1:0] prod;
		logic [ACC_W:0]    sum;
		band_energy_t      r;
		int                n;
		n = (filters_used == 0) ? 1 :
			((filters_used > FILT_CNT) ? FILT_CNT : int'(filters_used));
		if (req_type == REQ_WEIGHT) begin
			if (filter_sel < FILT_CNT && bin_index < NUM_BINS)
				weight_mem[filter_sel][bin_index] = weight_value;
			return;
		end
		if (bin_index < NUM_BINS) begin
			for (int j = 0; j < n; j++) begin
				prod = PROD_W'(bin_power) * PROD_W'(weight_mem[j][bin_index]);
				sum = {1'b0, band_acc[j]} + (ACC_W + 1)'(prod);
				band_acc[j] = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
			end
		end
		if (!last_bin)
			return;
		for (int j = 0; j < n; j++) begin
			r.id = FSEL_W'(j);
			r.loge = log2_energy(band_acc[j]);
			r.done = (j == n - 1);
			band_energy_q.insert(band_energy_q.size(), r);
		end
		// frame end drops every accumulator, active or not
		for (int j = 0; j < FILT_CNT; j++)
			band_acc[j] = '0;
	endtask

	task automatic check_result();
		band_energy_t r;
		if (band_energy_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected result filter %0d log %0d",
				filter_id, log_energy));
			return;
		end
		r = band_energy_q.pop_front();
		if (filter_id !== r.id)
			flag_mismatch($sformatf("filter_id %0d, want %0d", filter_id, r.id));
		if (log_energy !== r.loge)
			flag_mismatch($sformatf("filter %0d log_energy %0d, want %0d",
				r.id, log_energy, r.loge));
		if (frame_done !== r.done)
			flag_mismatch($sformatf("filter %0d frame_done %b, want %b",
				r.id, frame_done, r.done));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FILT_CNT; j++)
				band_acc[j] = '0;
			filters_used = FUSED_RESET;
			band_energy_q.delete();
			pending <= 0;
		end else begin
			if (result_valid)
				check_result();
			if (cfg_valid && cfg_ready)
				filters_used = cfg_data;
			if (start && !busy)
				take_request();
			pending <= band_energy_q.size();
		end
	end

endmodule

### verif/testbench.sv
// testbench: drives weight loads, spectrum bins and filter count writes into the
// mel filterbank log energy unit; mfle_checker predicts and compares the results
// depends on mfle_pkg, mel_filterbank_log_energy_unit, mfle_checker
`timescale 1ns / 100ps

module testbench;
	import mfle_pkg::*;

	localparam int NF           = FILT_CNT_DEF;
	localparam int NB           = NUM_BINS_DEF;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 70;
	localparam int QUIET_TAIL   = 20;
	localparam int SAT_BINS     = 260;
	localparam int POOL_SIZE    = 3;
	localparam logic REQ_POWER  = 1'b1;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	logic [FSEL_W-1:0] filter_sel;
	logic [BIN_W-1:0] bin_index;
	logic [WEIGHT_W-1:0] weight_value;
	logic [POWER_W-1:0] bin_power;
	logic last_bin;
	logic cfg_valid;
	logic cfg_ready;
	logic [FUSED_W-1:0] cfg_data;
	logic result_valid;
	logic [FSEL_W-1:0] filter_id;
	logic signed [LOG_W-1:0] log_energy;
	logic frame_done;
	int pending;
	int fail_count;

	int cycle_count = 0;
	int items_sent = 0;
	bit gaps_on = 1'b0;
	bit weight_set [NF][NB];
	logic [FUSED_W-1:0] fused_now = FUSED_RESET;
	int bin_pool [POOL_SIZE];

	always #1 clk = ~clk;

	mel_filterbank_log_energy_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.filter_sel   (filter_sel),
		.bin_index    (bin_index),
		.weight_value (weight_value),
		.bin_power    (bin_power),
		.last_bin     (last_bin),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.filter_id    (filter_id),
		.log_energy   (log_energy),
		.frame_done   (frame_done)
	);

	mfle_checker #(.FILT_CNT(NF), .NUM_BINS(NB)) u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.filter_sel   (filter_sel),
		.bin_index    (bin_index),
		.weight_value (weight_value),
		.bin_power    (bin_power),
		.last_bin     (last_bin),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.filter_id    (filter_id),
		.log_energy   (log_energy),
		.frame_done   (frame_done),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [POWER_W-1:0] pick_power();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return POWER_W'($urandom_range(0, 1023));
			default: return POWER_W'($urandom);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			3: return WEIGHT_W'($urandom_range(0, 63));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// one request transfer, with an optional idle burst ahead of it
	task automatic push_item(input logic rq, input logic [FSEL_W-1:0] fs,
			input logic [BIN_W-1:0] bn, input logic [WEIGHT_W-1:0] wv,
			input logic [POWER_W-1:0] pw, input logic lb);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			// sometimes let the unit go idle first so the gap also lands there
			if ($urandom_range(0, 1) == 1) begin
				@(posedge clk);
				while (busy) @(posedge clk);
			end
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		filter_sel <= fs;
		bin_index <= bn;
		weight_value <= wv;
		bin_power <= pw;
		last_bin <= lb;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic put_weight(input int f, input int b, input logic [WEIGHT_W-1:0] w);
		push_item(REQ_WEIGHT, FSEL_W'(f), BIN_W'(b), w, POWER_W'($urandom),
			1'($urandom));
		if (f < NF && b < NB)
			weight_set[f][b] = 1'b1;
	endtask

	// loads any not yet written weight the active filters would read at this bin before sending it
	task automatic put_bin(input int b, input logic [POWER_W-1:0] p, input logic lb);
		int n;
		n = (fused_now == 0) ? 1 : ((fused_now > NF) ? NF : int'(fused_now));
		if (b < NB) begin
			for (int j = 0; j < n; j++)
				if (!weight_set[j][b])
					put_weight(j, b, pick_weight());
		end
		push_item(REQ_POWER, FSEL_W'($urandom), BIN_W'(b), WEIGHT_W'($urandom), p, lb);
	endtask

	task automatic settle_block();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// weight writes and inner bins give no result, so the unit may still be working
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_filters(input logic [FUSED_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		fused_now = v;
	endtask

	initial begin
		int rand_start;
		int phase;
		int frame_len;
		int b;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WEIGHT;
		filter_sel = '0;
		bin_index = '0;
		weight_value = '0;
		bin_power = '0;
		last_bin = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: weight extremes, out of range writes, zero energy, full scale
		gaps_on = 1'b1;
		set_filters(5'd2);
		put_weight(0, 0, 16'h0000);
		put_weight(1, 0, 16'hFFFF);
		put_weight(0, NB - 1, 16'h8000);
		put_weight(1, NB - 1, 16'h0001);
		put_weight(31, 0, 16'h1234);
		put_weight(0, NB, 16'hFFFF);
		put_weight(0, 511, 16'hFFFF);
		put_bin(0, '0, 1'b1);
		put_bin(0, '1, 1'b0);
		put_bin(NB - 1, '1, 1'b1);
		// bin past the spectrum adds nothing but still closes the frame
		put_bin(511, '1, 1'b1);
		put_bin(NB - 1, 32'd1, 1'b1);
		put_bin(0, 32'h0001_0000, 1'b0);
		put_weight(0, 0, 16'h4000);
		put_bin(0, 32'h0001_0000, 1'b1);
		settle_block();
		set_filters(5'd0);
		put_bin(NB - 1, 32'h0001_0000, 1'b1);
		settle_block();

		// one filter at full weight and power until the accumulator saturates
		gaps_on = 1'b0;
		set_filters(5'd1);
		put_weight(0, 5, 16'hFFFF);
		for (int i = 0; i < SAT_BINS; i++)
			put_bin(5, '1, i == SAT_BINS - 1);
		settle_block();

		bin_pool[0] = 0;
		bin_pool[1] = NB - 1;
		for (int i = 2; i < POOL_SIZE; i++)
			bin_pool[i] = $urandom_range(1, NB - 2);

		rand_start = items_sent;
		phase = 0;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			case (phase)
				0: set_filters(5'd1);
				1: set_filters(5'd31);
				2: set_filters(5'd0);
				3: set_filters(FUSED_W'(NF));
				default: set_filters(FUSED_W'($urandom_range(0, 31)));
			endcase
			repeat ($urandom_range(1, 4)) begin
				gaps_on = (items_sent - rand_start < RANDOM_ITEMS - QUIET_TAIL) &&
					($urandom_range(0, 3) != 0);
				frame_len = $urandom_range(1, 6);
				for (int k = 0; k < frame_len; k++) begin
					case ($urandom_range(0, 11))
						0: put_weight($urandom_range(0, NF - 1),
							bin_pool[$urandom_range(0, POOL_SIZE - 1)], pick_weight());
						1: put_weight($urandom_range(NF, 31), $urandom_range(0, 511),
							WEIGHT_W'($urandom));
						2: put_weight($urandom_range(0, 31), $urandom_range(NB, 511),
							WEIGHT_W'($urandom));
						default: ;
					endcase
					if ($urandom_range(0, 9) == 0)
						b = $urandom_range(NB, 511);
					else
						b = bin_pool[$urandom_range(0, POOL_SIZE - 1)];
					put_bin(b, pick_power(), k == frame_len - 1);
				end
			end
			settle_block();
			phase++;
		end

		gaps_on = 1'b0;
		settle_block();
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
